// ===== rtl/core/tlfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tlfs_pkg
// shared types and constants of the two-level feedback scheduler
// ----------------------------------------------------------------------------
package tlfs_pkg;

    // field widths
    localparam int TID_W     = 4;
    localparam int OP_W      = 3;
    localparam int QUANT_W   = 4;
    localparam int RUN_W     = 5;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // opcodes
    localparam logic [OP_W-1:0] OP_NEW   = 3'd0;
    localparam logic [OP_W-1:0] OP_ENQ   = 3'd1;
    localparam logic [OP_W-1:0] OP_PICK  = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
    localparam logic [OP_W-1:0] OP_STEAL = 3'd4;

    // register indexes (word address)
    localparam logic [1:0] REG_INIT_Q = 2'd0;
    localparam logic [1:0] REG_MAX_Q  = 2'd1;
    localparam logic [1:0] REG_MIN_Q  = 2'd2;

    // register reset values
    localparam logic [QUANT_W-1:0] INIT_Q_RST = 4'd3;
    localparam logic [QUANT_W-1:0] MAX_Q_RST  = 4'd5;
    localparam logic [QUANT_W-1:0] MIN_Q_RST  = 4'd1;

    // runnable count ceiling
    localparam logic [RUN_W-1:0] RUN_CAP = 5'd16;

    // input item
    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [TID_W-1:0] task_id;
        logic             is_idle;
        logic             was_runnable;
        logic             last_tick;
    } t_in;

    // result item
    typedef struct packed {
        logic [TID_W-1:0] task_out;
        logic             task_found;
        logic             resched_req;
        logic [RUN_W-1:0] runnable_count;
    } t_out;

    // configuration values
    typedef struct packed {
        logic [QUANT_W-1:0] init_q;
        logic [QUANT_W-1:0] max_q;
        logic [QUANT_W-1:0] min_q;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic q_pop;
        logic t_read_dec;
        logic t_read_q;
        logic t_update;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            id_ok;
        logic            cur_ok;
        logic            q0_empty;
        logic            q1_empty;
    } t_stat;

endpackage

// ===== rtl/core/two_level_feedback_scheduler.sv =====
// ----------------------------------------------------------------------------
// two_level_feedback_scheduler
// single-cpu runqueue with two fifo levels and per-task quantum feedback
//
//   channel  direction  handshake                    payload
//   input    in         i_in_valid / o_in_ready      i_in_data  (t_in)
//   output   out        o_out_valid / i_out_ready    o_out_data (t_out)
//   config   in/out     psel penable pwrite pready   paddr pwdata prdata
//
// the sequencer steps an item through decode, a registered read of the queue
// memories for pick and steal that find a task, a registered read of the task
// table and the table update; an item that touches nothing goes to the result.
// reset is synchronous active low; queues come up empty and on-queue flags
// clear, no clearing pass.
// a new item is taken while the previous result waits in the output register;
// a held output stalls the next item only at its final transfer.
// ----------------------------------------------------------------------------
module two_level_feedback_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  tlfs_pkg::t_in                i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output tlfs_pkg::t_out               o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tlfs_pkg::PADDR_W-1:0] paddr,
    input  logic [tlfs_pkg::PDATA_W-1:0] pwdata,
    output logic [tlfs_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    tlfs_pkg::t_cfg  cfg;
    tlfs_pkg::t_cmd  cmd;
    tlfs_pkg::t_stat stat;

    // configuration registers
    tlfs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer
    tlfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // queues and task table
    tlfs_dpath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_data  (i_in_data),
        .o_data  (o_out_data)
    );

endmodule

// ===== rtl/core/tlfs_regs.sv =====
// ----------------------------------------------------------------------------
// tlfs_regs
// apb register file holding the quantum settings
// ----------------------------------------------------------------------------
module tlfs_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tlfs_pkg::PADDR_W-1:0] paddr,
    input  logic [tlfs_pkg::PDATA_W-1:0] pwdata,
    output logic [tlfs_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output tlfs_pkg::t_cfg               o_cfg
);

    logic [tlfs_pkg::QUANT_W-1:0] r_init_q;
    logic [tlfs_pkg::QUANT_W-1:0] r_max_q;
    logic [tlfs_pkg::QUANT_W-1:0] r_min_q;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_q <= tlfs_pkg::INIT_Q_RST;
            r_max_q  <= tlfs_pkg::MAX_Q_RST;
            r_min_q  <= tlfs_pkg::MIN_Q_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                tlfs_pkg::REG_INIT_Q: r_init_q <= pwdata[tlfs_pkg::QUANT_W-1:0];
                tlfs_pkg::REG_MAX_Q:  r_max_q  <= pwdata[tlfs_pkg::QUANT_W-1:0];
                tlfs_pkg::REG_MIN_Q:  r_min_q  <= pwdata[tlfs_pkg::QUANT_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (paddr[3:2])
            tlfs_pkg::REG_INIT_Q: prdata = tlfs_pkg::PDATA_W'(r_init_q);
            tlfs_pkg::REG_MAX_Q:  prdata = tlfs_pkg::PDATA_W'(r_max_q);
            tlfs_pkg::REG_MIN_Q:  prdata = tlfs_pkg::PDATA_W'(r_min_q);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = '{init_q: r_init_q, max_q: r_max_q, min_q: r_min_q};

endmodule

// ===== rtl/core/tlfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlfs_ctrl
// sequencer that steps one item through decode and, as the opcode needs, queue
// read, table read and table update, then hands the result to the output register
// ----------------------------------------------------------------------------
module tlfs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  tlfs_pkg::t_stat i_stat,
    output tlfs_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_QWAIT,
        S_TUPD,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;
    logic   is_qop;
    logic   q_avail;
    logic   t_needed;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    // decode of the held item
    assign is_qop   = (i_stat.op == tlfs_pkg::OP_PICK) || (i_stat.op == tlfs_pkg::OP_STEAL);
    assign q_avail  = !i_stat.q0_empty || !i_stat.q1_empty;
    assign t_needed = (((i_stat.op == tlfs_pkg::OP_NEW) || (i_stat.op == tlfs_pkg::OP_ENQ))
                       && i_stat.id_ok)
                      || ((i_stat.op == tlfs_pkg::OP_TICK) && i_stat.cur_ok);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                if (is_qop && q_avail) begin
                    o_cmd.q_pop = 1'b1;
                    n_state     = S_QWAIT;
                end else if (t_needed) begin
                    o_cmd.t_read_dec = 1'b1;
                    n_state          = S_TUPD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_QWAIT: begin
                o_cmd.t_read_q = 1'b1;
                n_state        = S_TUPD;
            end
            S_TUPD: begin
                o_cmd.t_update = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/tlfs_dpath.sv =====
// ----------------------------------------------------------------------------
// tlfs_dpath
// datapath: two fifo levels, per-task table, current task and runnable count
// ----------------------------------------------------------------------------
module tlfs_dpath #(
    parameter int MAX_TASKS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tlfs_pkg::t_cfg i_cfg,
    input  tlfs_pkg::t_cmd i_cmd,
    output tlfs_pkg::t_stat o_stat,
    input  tlfs_pkg::t_in  i_data,
    output tlfs_pkg::t_out o_data
);

    localparam int TID_W = tlfs_pkg::TID_W;
    localparam int QW    = tlfs_pkg::QUANT_W;
    localparam int RW    = tlfs_pkg::RUN_W;
    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int QC_W  = $clog2(MAX_TASKS + 1);
    localparam int QS_W  = QC_W + 1;
    localparam int EXT_W = (IDX_W > TID_W) ? IDX_W : TID_W;
    localparam int CMP_W = (QC_W > TID_W) ? QC_W : TID_W;
    localparam int SL_W  = 5;

    localparam int FL_FROM_IO = 0;
    localparam int FL_NEW     = 1;
    localparam int FL_ONQ     = 2;

    typedef struct packed {
        logic [2:0]      flags;
        logic [SL_W-1:0] slice;
        logic [QW-1:0]   quantum;
    } t_entry;

    // task id to table index
    function automatic logic [IDX_W-1:0] to_idx(input logic [TID_W-1:0] id);
        logic [EXT_W-1:0] e;
        e = EXT_W'(id);
        return e[IDX_W-1:0];
    endfunction

    // circular slot of a sum below twice the depth
    function automatic logic [IDX_W-1:0] wrap_slot(input logic [QS_W-1:0] s);
        logic [QS_W-1:0] t;
        t = (s >= QS_W'(MAX_TASKS)) ? s - QS_W'(MAX_TASKS) : s;
        return t[IDX_W-1:0];
    endfunction

    // storage
    t_entry           tbl    [MAX_TASKS];
    logic [TID_W-1:0] q0_mem [MAX_TASKS];
    logic [TID_W-1:0] q1_mem [MAX_TASKS];

    tlfs_pkg::t_in    r_in;
    tlfs_pkg::t_out   r_out;
    t_entry           r_ent;
    logic [IDX_W-1:0] r_tsel;
    logic [TID_W-1:0] r_q_rd;
    logic [IDX_W-1:0] r_head0;
    logic [IDX_W-1:0] r_head1;
    logic [QC_W-1:0]  r_cnt0;
    logic [QC_W-1:0]  r_cnt1;
    logic [IDX_W-1:0] r_cur;
    logic             r_cur_vld;
    logic [RW-1:0]    r_run;
    logic [TID_W-1:0] r_t_out;
    logic             r_found;
    logic             r_resched;
    logic [MAX_TASKS-1:0] r_onq;

    // pop selection
    logic             is_pick;
    logic             use_l1;
    logic [IDX_W-1:0] sel_head;
    logic [QC_W-1:0]  sel_cnt;
    logic [IDX_W-1:0] rd_slot;
    logic [IDX_W-1:0] dec_addr;

    // update results
    t_entry           n_ent;
    logic             n_wr;
    logic             n_push0;
    logic             n_push1;
    logic             n_run_inc;
    logic             n_run_dec;
    logic             n_resched;
    logic [QW-1:0]    q_tmp;
    logic [SL_W-1:0]  s_tmp;
    logic             ent_onq;

    assign o_stat = '{
        op:       r_in.opcode,
        id_ok:    CMP_W'(r_in.task_id) < CMP_W'(MAX_TASKS),
        cur_ok:   r_cur_vld && !r_in.is_idle,
        q0_empty: (r_cnt0 == '0),
        q1_empty: (r_cnt1 == '0)
    };

    // queue end chosen by pick or steal
    assign is_pick  = (r_in.opcode == tlfs_pkg::OP_PICK);
    assign use_l1   = is_pick ? (r_cnt0 == '0) : (r_cnt1 != '0);
    assign sel_head = use_l1 ? r_head1 : r_head0;
    assign sel_cnt  = use_l1 ? r_cnt1 : r_cnt0;
    assign rd_slot  = is_pick ? sel_head
                              : wrap_slot(QS_W'(sel_head) + QS_W'(sel_cnt) - QS_W'(1));
    assign dec_addr = (r_in.opcode == tlfs_pkg::OP_TICK) ? r_cur : to_idx(r_in.task_id);

    // on-queue flag of the selected task, held in resettable registers
    assign ent_onq = r_onq[r_tsel];

    // table entry update per opcode
    always_comb begin
        n_ent     = r_ent;
        n_ent.flags[FL_ONQ] = ent_onq;
        n_wr      = 1'b0;
        n_push0   = 1'b0;
        n_push1   = 1'b0;
        n_run_inc = 1'b0;
        n_run_dec = 1'b0;
        n_resched = 1'b0;
        q_tmp     = r_ent.quantum;
        s_tmp     = r_ent.slice;
        case (r_in.opcode)
            tlfs_pkg::OP_NEW: begin
                n_wr                  = 1'b1;
                n_ent.quantum         = i_cfg.init_q;
                n_ent.slice           = SL_W'(i_cfg.init_q);
                n_ent.flags[FL_FROM_IO] = 1'b1;
                n_ent.flags[FL_NEW]   = 1'b1;
            end
            tlfs_pkg::OP_ENQ: begin
                if (!ent_onq && !r_in.is_idle) begin
                    n_wr = 1'b1;
                    if (!r_ent.flags[FL_FROM_IO]) begin
                        n_push1 = 1'b1;
                        if (q_tmp > i_cfg.min_q) begin
                            q_tmp = q_tmp - QW'(1);
                        end
                    end else begin
                        n_push0 = 1'b1;
                        if (q_tmp < i_cfg.max_q && !r_ent.flags[FL_NEW]) begin
                            q_tmp = q_tmp + QW'(1);
                        end
                        n_ent.flags[FL_NEW] = 1'b0;
                    end
                    n_ent.flags[FL_ONQ] = 1'b1;
                    n_ent.quantum       = q_tmp;
                    n_ent.slice         = SL_W'(q_tmp);
                    n_run_inc           = !r_in.was_runnable;
                end
            end
            tlfs_pkg::OP_TICK: begin
                n_wr = 1'b1;
                if (s_tmp != '0) begin
                    s_tmp = s_tmp - SL_W'(1);
                end
                n_ent.slice = s_tmp;
                if (s_tmp == '0) begin
                    n_ent.flags[FL_FROM_IO] = 1'b0;
                    n_resched               = 1'b1;
                end
                if (r_in.last_tick) begin
                    n_ent.flags[FL_FROM_IO] = 1'b1;
                    n_run_dec               = 1'b1;
                end
            end
            tlfs_pkg::OP_PICK: begin
                n_wr                = 1'b1;
                n_ent.flags[FL_ONQ] = 1'b0;
            end
            tlfs_pkg::OP_STEAL: begin
                n_wr                = 1'b1;
                n_ent.flags[FL_ONQ] = 1'b0;
                n_run_dec           = 1'b1;
            end
            default: ;
        endcase
    end

    // input item and per-item result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in      <= i_data;
            r_t_out   <= '0;
            r_found   <= 1'b0;
            r_resched <= 1'b0;
        end
        if (i_cmd.t_read_q) begin
            r_t_out <= r_q_rd;
            r_found <= 1'b1;
        end
        if (i_cmd.t_update) begin
            r_resched <= n_resched;
        end
        if (i_cmd.out_load) begin
            r_out <= '{task_out: r_t_out, task_found: r_found,
                       resched_req: r_resched, runnable_count: r_run};
        end
    end

    // queue memory read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_pop) begin
            r_q_rd <= use_l1 ? q1_mem[rd_slot] : q0_mem[rd_slot];
        end
    end

    // queue memory writes on enqueue
    always_ff @(posedge i_clk) begin
        if (i_cmd.t_update && n_push0 && (r_cnt0 < QC_W'(MAX_TASKS))) begin
            q0_mem[wrap_slot(QS_W'(r_head0) + QS_W'(r_cnt0))] <= r_in.task_id;
        end
        if (i_cmd.t_update && n_push1 && (r_cnt1 < QC_W'(MAX_TASKS))) begin
            q1_mem[wrap_slot(QS_W'(r_head1) + QS_W'(r_cnt1))] <= r_in.task_id;
        end
    end

    // task table read and write
    always_ff @(posedge i_clk) begin
        if (i_cmd.t_read_dec) begin
            r_tsel <= dec_addr;
            r_ent  <= tbl[dec_addr];
        end else if (i_cmd.t_read_q) begin
            r_tsel <= to_idx(r_q_rd);
            r_ent  <= tbl[to_idx(r_q_rd)];
        end
        if (i_cmd.t_update && n_wr) begin
            tbl[r_tsel] <= n_ent;
        end
    end

    // queue pointers, on-queue flags, current task and runnable count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head0   <= '0;
            r_head1   <= '0;
            r_cnt0    <= '0;
            r_cnt1    <= '0;
            r_cur_vld <= 1'b0;
            r_cur     <= '0;
            r_run     <= '0;
            r_onq     <= '0;
        end else begin
            if (i_cmd.q_pop) begin
                if (use_l1) begin
                    r_cnt1 <= r_cnt1 - QC_W'(1);
                    if (is_pick) begin
                        r_head1 <= wrap_slot(QS_W'(r_head1) + QS_W'(1));
                    end
                end else begin
                    r_cnt0 <= r_cnt0 - QC_W'(1);
                    if (is_pick) begin
                        r_head0 <= wrap_slot(QS_W'(r_head0) + QS_W'(1));
                    end
                end
            end
            if (i_cmd.t_update) begin
                if (n_wr) begin
                    r_onq[r_tsel] <= n_ent.flags[FL_ONQ];
                end
                if (n_push0 && (r_cnt0 < QC_W'(MAX_TASKS))) begin
                    r_cnt0 <= r_cnt0 + QC_W'(1);
                end
                if (n_push1 && (r_cnt1 < QC_W'(MAX_TASKS))) begin
                    r_cnt1 <= r_cnt1 + QC_W'(1);
                end
                if (is_pick) begin
                    r_cur     <= r_tsel;
                    r_cur_vld <= 1'b1;
                end
                if (n_run_inc && (r_run < tlfs_pkg::RUN_CAP)) begin
                    r_run <= r_run + RW'(1);
                end else if (n_run_dec && (r_run != '0)) begin
                    r_run <= r_run - RW'(1);
                end
            end
        end
    end

    assign o_data = r_out;

endmodule

// ===== tb/tlfs_result_checker.sv =====
// ----------------------------------------------------------------------------
// tlfs_result_checker
// watches the item, result and register ports of the two-level feedback
// scheduler, runs a software copy of the runqueue on every accepted item and
// compares each accepted result field by field with the oldest expected one
// ----------------------------------------------------------------------------
module tlfs_result_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  tlfs_pkg::t_in                i_in_data,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  tlfs_pkg::t_out               i_out_data,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic                         i_pready,
    input  logic [tlfs_pkg::PADDR_W-1:0] i_paddr,
    input  logic [tlfs_pkg::PDATA_W-1:0] i_pwdata,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TASKS = 16;
    localparam int LVL_FAST  = 0;
    localparam int LVL_SLOW  = 1;

    // shadow runqueue: two fifo levels
    logic [tlfs_pkg::TID_W-1:0]   lvl_slot  [2][NUM_TASKS];
    logic [3:0]                   lvl_head  [2];
    logic [4:0]                   lvl_count [2];

    // shadow per-task table
    logic [tlfs_pkg::QUANT_W-1:0] task_quant   [NUM_TASKS];
    logic [4:0]                   task_slice   [NUM_TASKS];
    logic                         task_from_io [NUM_TASKS];
    logic                         task_is_new  [NUM_TASKS];
    logic                         task_on_q    [NUM_TASKS];

    logic                         cur_valid;
    logic [tlfs_pkg::TID_W-1:0]   run_task;
    logic [tlfs_pkg::RUN_W-1:0]   run_total;
    logic [tlfs_pkg::QUANT_W-1:0] cfg_init;
    logic [tlfs_pkg::QUANT_W-1:0] cfg_max;
    logic [tlfs_pkg::QUANT_W-1:0] cfg_min;

    tlfs_pkg::t_out               awaited_results [$];
    int                           fail_total = 0;
    int                           pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    // append a task at the tail of a level
    function automatic void level_push(int lv, logic [tlfs_pkg::TID_W-1:0] id);
        logic [3:0] idx;
        if (lvl_count[lv] < NUM_TASKS) begin
            idx = lvl_head[lv] + lvl_count[lv][3:0];
            lvl_slot[lv][idx] = id;
            lvl_count[lv] = lvl_count[lv] + 5'd1;
        end
    endfunction

    function automatic bit level_pop_head(int lv, output logic [tlfs_pkg::TID_W-1:0] id);
        id = '0;
        if (lvl_count[lv] == 0)
            return 1'b0;
        id = lvl_slot[lv][lvl_head[lv]];
        lvl_head[lv] = lvl_head[lv] + 4'd1;
        lvl_count[lv] = lvl_count[lv] - 5'd1;
        return 1'b1;
    endfunction

    function automatic bit level_pop_tail(int lv, output logic [tlfs_pkg::TID_W-1:0] id);
        logic [3:0] idx;
        id = '0;
        if (lvl_count[lv] == 0)
            return 1'b0;
        idx = lvl_head[lv] + lvl_count[lv][3:0] - 4'd1;
        id = lvl_slot[lv][idx];
        lvl_count[lv] = lvl_count[lv] - 5'd1;
        return 1'b1;
    endfunction

    // apply one operation to the shadow runqueue and return its result
    function automatic tlfs_pkg::t_out schedule_step(tlfs_pkg::t_in it);
        tlfs_pkg::t_out               res;
        logic [tlfs_pkg::TID_W-1:0]   tid;
        logic [tlfs_pkg::QUANT_W-1:0] q;
        logic [4:0]                   s;
        bit                           found;
        res = '0;
        tid = it.task_id;
        case (it.opcode)
            tlfs_pkg::OP_NEW: begin
                task_quant[tid]   = cfg_init;
                task_slice[tid]   = {1'b0, cfg_init};
                task_from_io[tid] = 1'b1;
                task_is_new[tid]  = 1'b1;
            end
            tlfs_pkg::OP_ENQ: begin
                // queued and idle tasks are left alone
                if (!task_on_q[tid] && !it.is_idle) begin
                    q = task_quant[tid];
                    if (!task_from_io[tid]) begin
                        level_push(LVL_SLOW, tid);
                        if (q > cfg_min)
                            q = q - 4'd1;
                    end else begin
                        level_push(LVL_FAST, tid);
                        if (q < cfg_max && !task_is_new[tid])
                            q = q + 4'd1;
                        task_is_new[tid] = 1'b0;
                    end
                    task_on_q[tid]  = 1'b1;
                    task_quant[tid] = q;
                    task_slice[tid] = {1'b0, q};
                    if (!it.was_runnable && run_total < tlfs_pkg::RUN_CAP)
                        run_total = run_total + 5'd1;
                end
            end
            tlfs_pkg::OP_PICK: begin
                found = level_pop_head(LVL_FAST, tid);
                if (!found)
                    found = level_pop_head(LVL_SLOW, tid);
                if (found) begin
                    task_on_q[tid] = 1'b0;
                    run_task  = tid;
                    cur_valid = 1'b1;
                    res.task_out   = tid;
                    res.task_found = 1'b1;
                end
            end
            tlfs_pkg::OP_TICK: begin
                if (cur_valid && !it.is_idle) begin
                    s = task_slice[run_task];
                    if (s > 0)
                        s = s - 5'd1;
                    task_slice[run_task] = s;
                    // slice used up: task drops to the slow level next time, unless this is its last tick
                    if (s == 0) begin
                        task_from_io[run_task] = 1'b0;
                        res.resched_req = 1'b1;
                    end
                    if (it.last_tick) begin
                        task_from_io[run_task] = 1'b1;
                        if (run_total > 0)
                            run_total = run_total - 5'd1;
                    end
                end
            end
            tlfs_pkg::OP_STEAL: begin
                found = level_pop_tail(LVL_SLOW, tid);
                if (!found)
                    found = level_pop_tail(LVL_FAST, tid);
                if (found) begin
                    task_on_q[tid] = 1'b0;
                    if (run_total > 0)
                        run_total = run_total - 5'd1;
                    res.task_out   = tid;
                    res.task_found = 1'b1;
                end
            end
            default: ;
        endcase
        res.runnable_count = run_total;
        return res;
    endfunction

    // sample transfers, predict and compare
    always @(posedge i_clk) begin
        tlfs_pkg::t_out exp_res;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                task_quant[i]   = '0;
                task_slice[i]   = '0;
                task_from_io[i] = 1'b0;
                task_is_new[i]  = 1'b0;
                task_on_q[i]    = 1'b0;
                lvl_slot[LVL_FAST][i] = '0;
                lvl_slot[LVL_SLOW][i] = '0;
            end
            lvl_head[LVL_FAST]  = '0;
            lvl_head[LVL_SLOW]  = '0;
            lvl_count[LVL_FAST] = '0;
            lvl_count[LVL_SLOW] = '0;
            cur_valid = 1'b0;
            run_task  = '0;
            run_total = '0;
            cfg_init  = tlfs_pkg::INIT_Q_RST;
            cfg_max   = tlfs_pkg::MAX_Q_RST;
            cfg_min   = tlfs_pkg::MIN_Q_RST;
            awaited_results.delete();
        end else begin
            // result transfer
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result, expected none, actual task_out=%0d "
                             , $time, i_out_data.task_out,
                             "found=%0b resched=%0b count=%0d", i_out_data.task_found,
                             i_out_data.resched_req, i_out_data.runnable_count);
                end else begin
                    exp_res = awaited_results.pop_front();
                    if (i_out_data.task_out !== exp_res.task_out
                            || i_out_data.task_found !== exp_res.task_found
                            || i_out_data.resched_req !== exp_res.resched_req
                            || i_out_data.runnable_count !== exp_res.runnable_count) begin
                        fail_total++;
                        $display("%0t: result mismatch, expected task_out=%0d found=%0b ",
                                 $time, exp_res.task_out, exp_res.task_found,
                                 "resched=%0b count=%0d, actual task_out=%0d found=%0b ",
                                 exp_res.resched_req, exp_res.runnable_count,
                                 i_out_data.task_out, i_out_data.task_found,
                                 "resched=%0b count=%0d", i_out_data.resched_req,
                                 i_out_data.runnable_count);
                    end
                end
            end
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[tlfs_pkg::PADDR_W-1:2])
                    tlfs_pkg::REG_INIT_Q: cfg_init = i_pwdata[tlfs_pkg::QUANT_W-1:0];
                    tlfs_pkg::REG_MAX_Q:  cfg_max  = i_pwdata[tlfs_pkg::QUANT_W-1:0];
                    tlfs_pkg::REG_MIN_Q:  cfg_min  = i_pwdata[tlfs_pkg::QUANT_W-1:0];
                    default: ;
                endcase
            end
            // item transfer
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(schedule_step(i_in_data));
        end
        pending_total = awaited_results.size();
    end

endmodule

// ===== tb/two_level_feedback_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// two_level_feedback_scheduler_test
// drives directed and random runqueue operations into the scheduler under
// several quantum settings, with random gaps and output stalls, and reports
// the verdict from the checker's failure count
// ----------------------------------------------------------------------------
module two_level_feedback_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 250;
    localparam int NUM_PHASES     = 7;
    localparam int DRAIN_CYCLES   = 8;

    // opcodes the block treats as no-ops
    localparam logic [tlfs_pkg::OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [tlfs_pkg::OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [tlfs_pkg::OP_W-1:0] OP_SPARE_HI  = 3'd7;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    tlfs_pkg::t_in                i_in_data;
    logic                         o_out_valid;
    logic                         i_out_ready;
    tlfs_pkg::t_out               o_out_data;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [tlfs_pkg::PADDR_W-1:0] paddr;
    logic [tlfs_pkg::PDATA_W-1:0] pwdata;
    logic [tlfs_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    int                           fail_count;
    int                           pending_count;
    int                           quiet_cycles = 0;
    logic                         allow_idle = 1'b1;
    logic [15:0]                  created = '0;

    two_level_feedback_scheduler dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    tlfs_result_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random ready bursts, always ready in the last phase
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (allow_idle && $urandom_range(0, 2) == 0)
                i_out_ready <= 1'b0;
            else
                i_out_ready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge i_clk);
        end
    end

    // register write: setup then access
    task automatic reg_write(logic [1:0] idx, logic [tlfs_pkg::QUANT_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(tlfs_pkg::PDATA_W-tlfs_pkg::QUANT_W){1'b0}}, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_quanta(logic [tlfs_pkg::QUANT_W-1:0] init_q,
                              logic [tlfs_pkg::QUANT_W-1:0] max_q,
                              logic [tlfs_pkg::QUANT_W-1:0] min_q);
        reg_write(tlfs_pkg::REG_INIT_Q, init_q);
        reg_write(tlfs_pkg::REG_MAX_Q, max_q);
        reg_write(tlfs_pkg::REG_MIN_Q, min_q);
    endtask

    // hold off new items until every result is back and the block is quiet
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one item transfer, with an optional random gap ahead of it
    task automatic send_item(tlfs_pkg::t_in item);
        int gap;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        if (item.opcode == tlfs_pkg::OP_NEW)
            created[item.task_id] = 1'b1;
        do
            @(posedge i_clk);
        while (!o_in_ready);
    endtask

    // mostly well-formed operations; enqueue only names tasks already created
    function automatic tlfs_pkg::t_in random_op();
        tlfs_pkg::t_in it;
        int            roll;
        it.task_id      = tlfs_pkg::TID_W'($urandom_range(0, 15));
        it.is_idle      = ($urandom_range(0, 9) == 0);
        it.was_runnable = 1'($urandom_range(0, 1));
        it.last_tick    = ($urandom_range(0, 4) == 0);
        roll = $urandom_range(0, 99);
        if (created == '0 || roll < 10) begin
            it.opcode = tlfs_pkg::OP_NEW;
        end else if (roll < 45) begin
            it.opcode = tlfs_pkg::OP_ENQ;
            it.was_runnable = ($urandom_range(0, 3) == 0);
            while (!created[it.task_id])
                it.task_id = tlfs_pkg::TID_W'($urandom_range(0, 15));
        end else if (roll < 65) begin
            it.opcode = tlfs_pkg::OP_PICK;
        end else if (roll < 90) begin
            it.opcode = tlfs_pkg::OP_TICK;
        end else if (roll < 97) begin
            it.opcode = tlfs_pkg::OP_STEAL;
        end else begin
            it.opcode = tlfs_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        return it;
    endfunction

    // stimulus
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_quanta(tlfs_pkg::INIT_Q_RST, tlfs_pkg::MAX_Q_RST, tlfs_pkg::MIN_Q_RST);

        // empty runqueue, no current task, spare opcodes
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_TICK, 4'd0, 1'b0, 1'b0, 1'b1});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_PICK, 4'd0, 1'b0, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_STEAL, 4'd15, 1'b1, 1'b1, 1'b1});
        send_item(tlfs_pkg::t_in'{OP_SPARE_LO, 4'd15, 1'b1, 1'b1, 1'b1});
        send_item(tlfs_pkg::t_in'{OP_SPARE_MID, 4'd0, 1'b0, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{OP_SPARE_HI, 4'd10, 1'b1, 1'b0, 1'b1});
        // create, first enqueue, queued and idle enqueue ignored
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_NEW, 4'd0, 1'b0, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_NEW, 4'd15, 1'b1, 1'b1, 1'b1});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_ENQ, 4'd0, 1'b0, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_ENQ, 4'd0, 1'b0, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_ENQ, 4'd15, 1'b1, 1'b0, 1'b0});
        // re-create a queued task, enqueue an already runnable task
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_NEW, 4'd0, 1'b0, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_ENQ, 4'd15, 1'b0, 1'b1, 1'b0});
        // pick, idle tick, run the slice down and past zero
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_PICK, 4'd7, 1'b0, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_TICK, 4'd0, 1'b1, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_TICK, 4'd0, 1'b0, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_TICK, 4'd0, 1'b0, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_TICK, 4'd0, 1'b0, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_TICK, 4'd0, 1'b0, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_TICK, 4'd0, 1'b0, 1'b0, 1'b1});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_TICK, 4'd0, 1'b0, 1'b0, 1'b0});
        // exhausted task to the slow level, then steal from both levels until empty
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_ENQ, 4'd0, 1'b0, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_STEAL, 4'd0, 1'b0, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_STEAL, 4'd0, 1'b0, 1'b0, 1'b0});
        send_item(tlfs_pkg::t_in'{tlfs_pkg::OP_STEAL, 4'd0, 1'b0, 1'b0, 1'b0});

        // random phases, each under its own quantum limits
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            case (p)
                0: set_quanta(4'd1, 4'd15, 4'd1);
                1: set_quanta(4'd15, 4'd15, 4'd15);
                2: set_quanta(4'd15, 4'd1, 4'd15);
                3: set_quanta(4'd1, 4'd1, 4'd1);
                4: set_quanta(4'd8, 4'd12, 4'd4);
                default: set_quanta(tlfs_pkg::QUANT_W'($urandom_range(1, 15)),
                                    tlfs_pkg::QUANT_W'($urandom_range(1, 15)),
                                    tlfs_pkg::QUANT_W'($urandom_range(1, 15)));
            endcase
            if (p == NUM_PHASES - 1)
                allow_idle = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_op());
        end

        // wait for the last results, then the verdict
        drain_results();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tlfs_pkg.sv
rtl/core/tlfs_regs.sv
rtl/core/tlfs_ctrl.sv
rtl/core/tlfs_dpath.sv
rtl/core/two_level_feedback_scheduler.sv
tb/tlfs_result_checker.sv
tb/two_level_feedback_scheduler_test.sv
